FILE: sv/i2cdw_pkg.sv
// ----------------------------------------------------------------------------
// i2cdw_pkg
// Shared types, controller status codes and byte selection for the I2C
// dual write sequencer.
// ----------------------------------------------------------------------------
package i2cdw_pkg;

   // item command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_POLL = 1'b1;

   // controller status codes
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_RESTART    = 8'h10;
   localparam logic [7:0] ST_ADDR_ACK   = 8'h18;
   localparam logic [7:0] ST_ADDR_NACK  = 8'h20;
   localparam logic [7:0] ST_DATA_ACK   = 8'h28;
   localparam logic [7:0] ST_DATA_NACK  = 8'h30;

   // register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_A      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_B      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_BYTE   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_RELOAD = 2'd3;
   localparam int CSR_DATA_W = 16;

   // timeout counter
   localparam int TIMEOUT_W = 17;
   localparam logic [15:0]          TIMEOUT_RELOAD_RESET = 16'd1000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_COUNT_RESET  = 17'd1000;

   // byte positions in the two frames
   localparam logic [2:0] IDX_FIRST_FRAME_END = 3'd3;
   localparam logic [2:0] IDX_DONE            = 3'd6;

   typedef struct packed {
      logic [7:0]  address_a;
      logic [7:0]  address_b;
      logic [7:0]  command_byte;
      logic [15:0] timeout_reload;
   } cfg_type;

   typedef struct packed {
      logic       command;
      logic [7:0] value_a;
      logic [7:0] value_b;
      logic       event_pending;
      logic [7:0] bus_status;
   } req_type;

   typedef struct packed {
      logic       load_data;
      logic [7:0] data_byte;
      logic       request_start;
      logic       request_stop;
      logic       clear_interrupt;
      logic       clear_start;
      logic       clear_ack;
      logic       busy_res;
      logic       timed_out;
   } rsp_type;

   // byte sent at a given position of the two frames
   function automatic logic [7:0] byte_at(
      input logic [2:0] idx,
      input cfg_type    cfg,
      input logic [7:0] data_a,
      input logic [7:0] data_b
   );
      logic [7:0] b;
      case (idx)
         3'd0:    b = cfg.address_a;
         3'd1:    b = cfg.command_byte;
         3'd2:    b = data_a;
         3'd3:    b = cfg.address_b;
         3'd4:    b = cfg.command_byte;
         3'd5:    b = data_b;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: sv/i2cdw_csr.sv
// ----------------------------------------------------------------------------
// i2cdw_csr
// Configuration registers: slave addresses, command byte, timeout reload.
// ----------------------------------------------------------------------------
module i2cdw_csr
   import i2cdw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes always taken
   assign csr_ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ADDRESS_A:      cfg_in.address_a      = csr_data[7:0];
            CSR_ADDRESS_B:      cfg_in.address_b      = csr_data[7:0];
            CSR_COMMAND_BYTE:   cfg_in.command_byte   = csr_data[7:0];
            CSR_TIMEOUT_RELOAD: cfg_in.timeout_reload = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address_a      <= 8'h00;
         cfg_ff.address_b      <= 8'h00;
         cfg_ff.command_byte   <= 8'h00;
         cfg_ff.timeout_reload <= TIMEOUT_RELOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/i2cdw_core.sv
// ----------------------------------------------------------------------------
// i2cdw_core
// Sequencer state and the per-item decision: maps a load or a status poll
// to controller requests and updates busy, byte index and timeout.
// ----------------------------------------------------------------------------
module i2cdw_core
   import i2cdw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic [2:0]           byte_index_ff, byte_index_in;
   logic [TIMEOUT_W-1:0] timeout_count_ff, timeout_count_in;
   logic [7:0]           data_a_ff, data_a_in;
   logic [7:0]           data_b_ff, data_b_in;
   logic [TIMEOUT_W-1:0] count_dec;
   logic [TIMEOUT_W-1:0] count_reload;

   assign count_dec    = timeout_count_ff - TIMEOUT_W'(1);
   assign count_reload = {1'b0, cfg.timeout_reload};

   // item decision
   always_comb begin
      busy_in          = busy_ff;
      byte_index_in    = byte_index_ff;
      timeout_count_in = timeout_count_ff;
      data_a_in        = data_a_ff;
      data_b_in        = data_b_ff;
      rsp              = '0;
      if (step) begin
         if (req.command == CMD_LOAD) begin
            data_a_in         = req.value_a;
            data_b_in         = req.value_b;
            busy_in           = 1'b1;
            rsp.request_start = 1'b1;
         end else if (busy_ff) begin
            timeout_count_in = count_dec;
            if (count_dec[TIMEOUT_W-1]) begin
               // timeout expired, abandon with stop
               timeout_count_in    = count_reload;
               busy_in             = 1'b0;
               rsp.request_stop    = 1'b1;
               rsp.clear_interrupt = 1'b1;
               rsp.clear_start     = 1'b1;
               rsp.clear_ack       = 1'b1;
               rsp.timed_out       = 1'b1;
            end else if (req.event_pending) begin
               case (req.bus_status)
                  ST_START: begin
                     timeout_count_in    = count_reload;
                     rsp.load_data       = 1'b1;
                     rsp.data_byte       = byte_at(3'd0, cfg, data_a_ff, data_b_ff);
                     byte_index_in       = 3'd1;
                     rsp.clear_interrupt = 1'b1;
                     rsp.clear_start     = 1'b1;
                  end
                  ST_RESTART: begin
                     rsp.load_data       = 1'b1;
                     rsp.data_byte       = byte_at(byte_index_ff, cfg, data_a_ff, data_b_ff);
                     byte_index_in       = byte_index_ff + 3'd1;
                     rsp.clear_interrupt = 1'b1;
                     rsp.clear_start     = 1'b1;
                  end
                  ST_ADDR_ACK: begin
                     rsp.load_data       = 1'b1;
                     rsp.data_byte       = byte_at(byte_index_ff, cfg, data_a_ff, data_b_ff);
                     byte_index_in       = byte_index_ff + 3'd1;
                     rsp.clear_interrupt = 1'b1;
                  end
                  ST_DATA_ACK: begin
                     if (byte_index_ff == IDX_DONE) begin
                        busy_in          = 1'b0;
                        rsp.request_stop = 1'b1;
                     end else if (byte_index_ff == IDX_FIRST_FRAME_END) begin
                        rsp.request_start = 1'b1;
                     end else begin
                        rsp.load_data = 1'b1;
                        rsp.data_byte = byte_at(byte_index_ff, cfg, data_a_ff, data_b_ff);
                        byte_index_in = byte_index_ff + 3'd1;
                     end
                     rsp.clear_interrupt = 1'b1;
                  end
                  ST_ADDR_NACK, ST_DATA_NACK: begin
                     busy_in             = 1'b0;
                     rsp.request_stop    = 1'b1;
                     rsp.clear_interrupt = 1'b1;
                     rsp.clear_start     = 1'b1;
                  end
                  default: begin
                     busy_in = busy_ff;
                  end
               endcase
            end
         end
      end
      rsp.busy_res = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         byte_index_ff    <= 3'd0;
         timeout_count_ff <= TIMEOUT_COUNT_RESET;
         data_a_ff        <= 8'h00;
         data_b_ff        <= 8'h00;
      end else begin
         busy_ff          <= busy_in;
         byte_index_ff    <= byte_index_in;
         timeout_count_ff <= timeout_count_in;
         data_a_ff        <= data_a_in;
         data_b_ff        <= data_b_in;
      end
   end

endmodule

FILE: sv/i2c_dual_write_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_dual_write_sequencer
// I2C master write sequencer for two three-byte frames joined by a
// repeated start, driven by controller status polls.
// ----------------------------------------------------------------------------
// Each req beat (a load or a status poll) yields exactly one rsp beat. A beat
// is registered on entry, decided against the sequencer state, and lands in
// the result register, so one beat per cycle is sustained while rsp_ready is
// high. The input register is refilled in the same cycle that its beat moves
// into a free result register.
// Configuration writes are taken at any time with csr_ready held high and
// should be issued only while no beat is in flight.
// ----------------------------------------------------------------------------
module i2c_dual_write_sequencer
   import i2cdw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic [7:0]             req_value_a,
   input  logic [7:0]             req_value_b,
   input  logic                   req_event_pending,
   input  logic [7:0]             req_bus_status,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_load_data,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_request_start,
   output logic                   rsp_request_stop,
   output logic                   rsp_clear_interrupt,
   output logic                   rsp_clear_start,
   output logic                   rsp_clear_ack,
   output logic                   rsp_busy_res,
   output logic                   rsp_timed_out
);

   cfg_type cfg;
   req_type req_ff, req_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff, rsp_in, rsp_next;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;

   i2cdw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cdw_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   // beat moves from input register to result register
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   // input register
   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff && !advance;
      if (req_valid && req_ready) begin
         req_in.command       = req_command;
         req_in.value_a       = req_value_a;
         req_in.value_b       = req_value_b;
         req_in.event_pending = req_event_pending;
         req_in.bus_status    = req_bus_status;
         req_valid_in         = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         rsp_in       = rsp_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_load_data       = rsp_ff.load_data;
   assign rsp_data_byte       = rsp_ff.data_byte;
   assign rsp_request_start   = rsp_ff.request_start;
   assign rsp_request_stop    = rsp_ff.request_stop;
   assign rsp_clear_interrupt = rsp_ff.clear_interrupt;
   assign rsp_clear_start     = rsp_ff.clear_start;
   assign rsp_clear_ack       = rsp_ff.clear_ack;
   assign rsp_busy_res        = rsp_ff.busy_res;
   assign rsp_timed_out       = rsp_ff.timed_out;

endmodule

FILE: tb/i2cdw_sequence_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2cdw_sequence_checker
// Watches the register, request and response channels of the dual write
// sequencer. It keeps its own copy of the registers and of the sequencer
// state, works out the response to each accepted request beat and compares
// every accepted response beat, in order, against it.
// ----------------------------------------------------------------------------
module i2cdw_sequence_checker
   import i2cdw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_command,
   input  logic [7:0]             req_value_a,
   input  logic [7:0]             req_value_b,
   input  logic                   req_event_pending,
   input  logic [7:0]             req_bus_status,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_load_data,
   input  logic [7:0]             rsp_data_byte,
   input  logic                   rsp_request_start,
   input  logic                   rsp_request_stop,
   input  logic                   rsp_clear_interrupt,
   input  logic                   rsp_clear_start,
   input  logic                   rsp_clear_ack,
   input  logic                   rsp_busy_res,
   input  logic                   rsp_timed_out,
   output int                     fail_count,
   output int                     outstanding,
   output int                     results_checked,
   output int                     frames_done,
   output int                     timeouts_seen,
   output int                     nack_aborts
);

   localparam int REPORT_LIMIT = 10;

   // register copy
   logic [7:0]  dev_a_address;
   logic [7:0]  dev_b_address;
   logic [7:0]  cmd_code;
   logic [15:0] poll_allowance;

   // sequencer state copy
   logic               transfer_active;
   logic [2:0]         frame_pos;
   logic signed [16:0] polls_left;
   logic [7:0]         byte_for_a;
   logic [7:0]         byte_for_b;

   rsp_type expected_results[$];

   // byte on the wire at the current frame position, then step the position
   function automatic logic [7:0] take_byte();
      logic [63:0] frames;
      logic [7:0]  picked;
      frames = {8'h00, 8'h00, byte_for_b, cmd_code, dev_b_address,
                byte_for_a, cmd_code, dev_a_address};
      picked = frames[frame_pos*8 +: 8];
      frame_pos = frame_pos + 3'd1;
      return picked;
   endfunction

   // response of the sequencer to one request beat, state updated in place
   function automatic rsp_type sequence_step(input req_type beat);
      rsp_type res;
      res = '0;
      if (beat.command == CMD_LOAD) begin
         byte_for_a = beat.value_a;
         byte_for_b = beat.value_b;
         transfer_active = 1'b1;
         res.request_start = 1'b1;
      end else if (transfer_active) begin
         polls_left = polls_left - 17'sd1;
         if (polls_left < 0) begin
            // transfer abandoned
            polls_left = {1'b0, poll_allowance};
            transfer_active = 1'b0;
            res.request_stop = 1'b1;
            res.clear_interrupt = 1'b1;
            res.clear_start = 1'b1;
            res.clear_ack = 1'b1;
            res.timed_out = 1'b1;
            timeouts_seen++;
         end else if (beat.event_pending) begin
            case (beat.bus_status)
               ST_START: begin
                  frame_pos = 3'd0;
                  polls_left = {1'b0, poll_allowance};
                  res.load_data = 1'b1;
                  res.data_byte = take_byte();
                  res.clear_interrupt = 1'b1;
                  res.clear_start = 1'b1;
               end
               ST_RESTART: begin
                  res.load_data = 1'b1;
                  res.data_byte = take_byte();
                  res.clear_interrupt = 1'b1;
                  res.clear_start = 1'b1;
               end
               ST_ADDR_ACK: begin
                  res.load_data = 1'b1;
                  res.data_byte = take_byte();
                  res.clear_interrupt = 1'b1;
               end
               ST_DATA_ACK: begin
                  if (frame_pos == IDX_DONE) begin
                     transfer_active = 1'b0;
                     res.request_stop = 1'b1;
                     frames_done++;
                  end else if (frame_pos == IDX_FIRST_FRAME_END) begin
                     res.request_start = 1'b1;
                  end else begin
                     res.load_data = 1'b1;
                     res.data_byte = take_byte();
                  end
                  res.clear_interrupt = 1'b1;
               end
               ST_ADDR_NACK, ST_DATA_NACK: begin
                  transfer_active = 1'b0;
                  res.request_stop = 1'b1;
                  res.clear_interrupt = 1'b1;
                  res.clear_start = 1'b1;
                  nack_aborts++;
               end
               default: ;
            endcase
         end
      end
      res.busy_res = transfer_active;
      return res;
   endfunction

   function automatic string show(input rsp_type r);
      return {$sformatf("load=%b byte=%h start=%b stop=%b ", r.load_data, r.data_byte,
                        r.request_start, r.request_stop),
              $sformatf("clr_int=%b clr_start=%b clr_ack=%b busy=%b to=%b",
                        r.clear_interrupt, r.clear_start, r.clear_ack, r.busy_res,
                        r.timed_out)};
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      req_type beat;
      if (reset) begin
         dev_a_address = 8'h00;
         dev_b_address = 8'h00;
         cmd_code = 8'h00;
         poll_allowance = TIMEOUT_RELOAD_RESET;
         transfer_active = 1'b0;
         frame_pos = 3'd0;
         polls_left = TIMEOUT_COUNT_RESET;
         byte_for_a = 8'h00;
         byte_for_b = 8'h00;
         expected_results.delete();
         fail_count = 0;
         results_checked = 0;
         frames_done = 0;
         timeouts_seen = 0;
         nack_aborts = 0;
         outstanding <= 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ADDRESS_A:      dev_a_address = csr_data[7:0];
               CSR_ADDRESS_B:      dev_b_address = csr_data[7:0];
               CSR_COMMAND_BYTE:   cmd_code = csr_data[7:0];
               CSR_TIMEOUT_RELOAD: poll_allowance = csr_data;
               default: ;
            endcase
         end

         // response beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = {rsp_load_data, rsp_data_byte, rsp_request_start, rsp_request_stop,
                   rsp_clear_interrupt, rsp_clear_start, rsp_clear_ack, rsp_busy_res,
                   rsp_timed_out};
            if (expected_results.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("[%0t] response beat with none pending: %s", $realtime, show(got));
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("[%0t] response %0d mismatch", $realtime, results_checked);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(got));
                  end
                  fail_count++;
               end
               results_checked++;
            end
         end

         // request beat: predict its response
         if (req_valid && req_ready) begin
            beat = {req_command, req_value_a, req_value_b, req_event_pending, req_bus_status};
            expected_results.push_back(sequence_step(beat));
         end

         outstanding <= expected_results.size();
      end
   end

endmodule

FILE: tb/i2c_dual_write_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_dual_write_sequencer_test
// Drives load and status poll beats into the dual write sequencer over
// several register settings and handshake idling patterns. A checker beside
// the block predicts and compares every response; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module i2c_dual_write_sequencer_test;
   import i2cdw_pkg::*;

   localparam int PHASE_BEATS     = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_SETTLE    = 6;

   // status sequence of a clean two frame write
   localparam logic [63:0] FRAME_SCRIPT = {ST_DATA_ACK, ST_DATA_ACK, ST_ADDR_ACK, ST_RESTART,
                                           ST_DATA_ACK, ST_DATA_ACK, ST_ADDR_ACK, ST_START};

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_command = CMD_LOAD;
   logic [7:0]             req_value_a = 8'h00;
   logic [7:0]             req_value_b = 8'h00;
   logic                   req_event_pending = 1'b0;
   logic [7:0]             req_bus_status = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_load_data;
   logic [7:0]             rsp_data_byte;
   logic                   rsp_request_start;
   logic                   rsp_request_stop;
   logic                   rsp_clear_interrupt;
   logic                   rsp_clear_start;
   logic                   rsp_clear_ack;
   logic                   rsp_busy_res;
   logic                   rsp_timed_out;

   int fail_count;
   int outstanding;
   int results_checked;
   int frames_done;
   int timeouts_seen;
   int nack_aborts;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_asked = 0;
   int hold_off_done = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int beats_offered = 0;
   int settings_applied = 0;

   i2c_dual_write_sequencer uut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_value_a         (req_value_a),
      .req_value_b         (req_value_b),
      .req_event_pending   (req_event_pending),
      .req_bus_status      (req_bus_status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_load_data       (rsp_load_data),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_request_start   (rsp_request_start),
      .rsp_request_stop    (rsp_request_stop),
      .rsp_clear_interrupt (rsp_clear_interrupt),
      .rsp_clear_start     (rsp_clear_start),
      .rsp_clear_ack       (rsp_clear_ack),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_timed_out       (rsp_timed_out)
   );

   i2cdw_sequence_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_value_a         (req_value_a),
      .req_value_b         (req_value_b),
      .req_event_pending   (req_event_pending),
      .req_bus_status      (req_bus_status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_load_data       (rsp_load_data),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_request_start   (rsp_request_start),
      .rsp_request_stop    (rsp_request_stop),
      .rsp_clear_interrupt (rsp_clear_interrupt),
      .rsp_clear_start     (rsp_clear_start),
      .rsp_clear_ack       (rsp_clear_ack),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_timed_out       (rsp_timed_out),
      .fail_count          (fail_count),
      .outstanding         (outstanding),
      .results_checked     (results_checked),
      .frames_done         (frames_done),
      .timeouts_seen       (timeouts_seen),
      .nack_aborts         (nack_aborts)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // response side: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_asked != hold_off_done) begin
         hold_off_done <= hold_off_asked;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles with no beat moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // byte registers get random upper bits, which must be dropped
   task automatic set_registers(input logic [7:0] addr_a, input logic [7:0] addr_b,
                                input logic [7:0] cmd, input logic [15:0] reload);
      write_register(CSR_ADDRESS_A, {8'($urandom_range(255)), addr_a});
      write_register(CSR_ADDRESS_B, {8'($urandom_range(255)), addr_b});
      write_register(CSR_COMMAND_BYTE, {8'($urandom_range(255)), cmd});
      write_register(CSR_TIMEOUT_RELOAD, reload);
      settings_applied++;
   endtask

   // one request beat, with random sender gaps ahead of it
   task automatic offer_beat(input logic command, input logic [7:0] va,
                             input logic [7:0] vb, input logic pending,
                             input logic [7:0] status);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_value_a <= va;
      req_value_b <= vb;
      req_event_pending <= pending;
      req_bus_status <= status;
      do @(posedge clock); while (!req_ready);
      beats_offered++;
   endtask

   task automatic load_values(input logic [7:0] va, input logic [7:0] vb);
      offer_beat(CMD_LOAD, va, vb, 1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   task automatic poll_status(input logic pending, input logic [7:0] status);
      offer_beat(CMD_POLL, 8'($urandom_range(255)), 8'($urandom_range(255)), pending, status);
   endtask

   // mostly the known status codes, sometimes anything
   function automatic logic [7:0] pick_status();
      case ($urandom_range(7))
         0:       return ST_START;
         1:       return ST_RESTART;
         2:       return ST_ADDR_ACK;
         3:       return ST_ADDR_NACK;
         4:       return ST_DATA_ACK;
         5:       return ST_DATA_NACK;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // load then the clean status sequence, with disturbances mixed in
   task automatic run_frame_pair(input logic [7:0] va, input logic [7:0] vb,
                                 input int noise_pct);
      int k;
      load_values(va, vb);
      for (k = 0; k < 8; k++) begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(3))
               0: poll_status(1'b0, 8'($urandom_range(255)));
               1: poll_status(1'b1, pick_status());
               2: begin
                  poll_status(1'b1, $urandom_range(1) ? ST_ADDR_NACK : ST_DATA_NACK);
                  return;
               end
               default: load_values(8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
         end
         poll_status(1'b1, FRAME_SCRIPT[k*8 +: 8]);
      end
   endtask

   task automatic run_noise(input int count);
      repeat (count) begin
         if ($urandom_range(4) == 0)
            load_values(8'($urandom_range(255)), 8'($urandom_range(255)));
         else
            poll_status($urandom_range(99) < 70, pick_status());
      end
   endtask

   // sender pauses until every predicted response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] addr_a, input logic [7:0] addr_b,
                            input logic [7:0] cmd, input logic [15:0] reload,
                            input int send_pct, input int stall_pct, input bit hold_off);
      int target;
      wait_for_drain();
      set_registers(addr_a, addr_b, cmd, reload);
      send_idle_pct = send_pct;
      rsp_stall_pct <= stall_pct;
      if (hold_off)
         hold_off_asked <= hold_off_asked + 1;
      target = beats_offered + PHASE_BEATS;
      while (beats_offered < target) begin
         if ($urandom_range(99) < 75)
            run_frame_pair(8'($urandom_range(255)), 8'($urandom_range(255)), 12);
         else
            run_noise($urandom_range(1, 6));
      end
   endtask

   initial begin
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full frames, past-the-end bytes, unknown codes, nacks
      set_registers(8'hA0, 8'h5E, 8'hC3, 16'd1000);
      poll_status(1'b1, ST_START);
      run_frame_pair(8'h00, 8'hFF, 0);
      load_values(8'hFF, 8'h00);
      for (k = 0; k < 7; k++)
         poll_status(1'b1, FRAME_SCRIPT[k*8 +: 8]);
      poll_status(1'b1, ST_RESTART);
      poll_status(1'b1, ST_ADDR_ACK);
      poll_status(1'b0, ST_START);
      poll_status(1'b1, 8'hFF);
      poll_status(1'b1, ST_ADDR_NACK);
      load_values(8'h5A, 8'hA5);
      poll_status(1'b1, ST_DATA_NACK);

      // zero reload: the poll after the start status times out
      wait_for_drain();
      write_register(CSR_TIMEOUT_RELOAD, 16'h0000);
      settings_applied++;
      load_values(8'h3C, 8'hC3);
      poll_status(1'b1, ST_START);
      poll_status(1'b1, ST_ADDR_ACK);

      // random phases over register settings and idling patterns
      run_phase(8'h00, 8'h00, 8'h00, 16'hFFFF, 0, 0, 1'b0);
      run_phase(8'hFF, 8'hFF, 8'hFF, 16'h0000, 55, 0, 1'b0);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'd1, 0, 55, 1'b0);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'd5, 21, 21, 1'b0);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(2, 20)), 0, 0, 1'b1);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'd12, 55, 0, 1'b0);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'd1000, 0, 55, 1'b0);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'd7, 21, 21, 1'b0);

      wait_for_drain();
      $display("summary: %0d request beats over %0d register settings, %0d responses checked",
               beats_offered, settings_applied, results_checked);
      $display("summary: %0d frame pairs completed, %0d timeouts, %0d nack aborts",
               frames_done, timeouts_seen, nack_aborts);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures, %0d responses missing", fail_count, outstanding);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/i2cdw_pkg.sv
sv/i2cdw_csr.sv
sv/i2cdw_core.sv
sv/i2c_dual_write_sequencer.sv
tb/i2cdw_sequence_checker.sv
tb/i2c_dual_write_sequencer_test.sv
